### sv/keyed_usage_histogram_table_assert.svh
// Assertion macros for the keyed usage histogram table.
// Used by keyed_usage_histogram_table.sv; no other dependencies.
`ifndef KEYED_USAGE_HISTOGRAM_TABLE_ASSERT_SVH
`define KEYED_USAGE_HISTOGRAM_TABLE_ASSERT_SVH
`ifndef ASSERT_OFF
`define KHIST_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define KHIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define KHIST_ASSERT_IMPLIES(lbl, clk, rst_n, ante, cons, msg)
`define KHIST_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

### sv/khist_pkg.sv
`timescale 1ns / 1ps
// Types and constants for the keyed usage histogram table.
// No dependencies; used by keyed_usage_histogram_table.
package khist_pkg;

    localparam int TABLE_ENTRIES_DEF = 64;

    localparam logic [30:0] TOTAL_MAX = 31'h7fffffff;
    localparam logic [31:0] COUNT_MAX = 32'hffffffff;
    localparam logic signed [31:0] LARGEST_NONE = -32'sd1;

    typedef enum logic [1:0] {
        OP_CLEAR   = 2'd0,
        OP_RECORD  = 2'd1,
        OP_READ    = 2'd2,
        OP_LARGEST = 2'd3
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FETCH,
        ST_LOAD,
        ST_UPDATE,
        ST_DONE
    } state_t;

    typedef struct packed {
        op_t         op;
        logic [31:0] class_key;
        logic [30:0] object_size;
        logic [5:0]  entry_index;
        logic [30:0] limit_value;
    } req_t;

    typedef struct packed {
        logic [5:0]         slot_used;
        logic               overflowed;
        logic               entry_valid;
        logic [31:0]        entry_key;
        logic [31:0]        entry_count;
        logic [30:0]        entry_total;
        logic signed [31:0] best_total;
        logic [6:0]         entries_used;
    } rsp_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] count;
        logic [30:0] total;
    } entry_t;

endpackage

### sv/keyed_usage_histogram_table.sv
`timescale 1ns / 1ps
// Keyed usage histogram table: top level, sequencer and entry memory.
// Depends on khist_pkg and keyed_usage_histogram_table_assert.svh.
//
//  channel | handshake            | payload         | accepted when
//  --------+----------------------+-----------------+------------------------
//  request | req_valid, req_stall | req  (req_t)    | req_valid && !req_stall
//  result  | rsp_valid, rsp_stall | rsp  (rsp_t)    | rsp_valid && !rsp_stall
//
// One item at a time; the entry memory has one read port, so a record or a
// largest-below search scans the used slots one per cycle. A clear goes
// straight to DONE; a read of a used slot passes FETCH and LOAD first.
// Reset empties the table at once (fill count); no clearing pass.
// A finished result waits in the output register while the next item is taken;
// the next result holds in DONE while that one is still stalled.
`include "keyed_usage_histogram_table_assert.svh"

module keyed_usage_histogram_table #(
    parameter int TABLE_ENTRIES = khist_pkg::TABLE_ENTRIES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_stall,
    input  khist_pkg::req_t  req,
    output logic             rsp_valid,
    input  logic             rsp_stall,
    output khist_pkg::rsp_t  rsp
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);
    localparam int CNT_W = $clog2(TABLE_ENTRIES + 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(TABLE_ENTRIES);
    localparam logic [IDX_W-1:0] LAST_SLOT = IDX_W'(TABLE_ENTRIES - 1);

    khist_pkg::entry_t tbl_mem [TABLE_ENTRIES];

    khist_pkg::state_t state_reg, state_next;
    khist_pkg::op_t    op_reg, op_next;
    logic [31:0]       key_reg, key_next;
    logic [30:0]       size_reg, size_next;
    logic [30:0]       limit_reg, limit_next;
    logic [CNT_W-1:0]  used_reg, used_next;
    logic [CNT_W-1:0]  iss_idx_reg, iss_idx_next;
    logic              pend_reg, pend_next;
    logic [IDX_W-1:0]  pend_idx_reg, pend_idx_next;
    logic [IDX_W-1:0]  slot_reg, slot_next;
    logic              ovf_reg, ovf_next;
    logic              rd_ok_reg, rd_ok_next;
    logic              any_reg, any_next;
    logic [30:0]       best_reg, best_next;
    khist_pkg::entry_t cur_reg, cur_next;
    khist_pkg::entry_t rd_q_reg;
    logic              out_valid_reg, out_valid_next;
    khist_pkg::rsp_t   rsp_reg, rsp_next;

    logic              accept;
    logic              hit;
    logic              scan_end;
    logic              table_full;
    logic              idx_ok;
    logic              out_free;
    logic [IDX_W-1:0]  rd_addr;
    logic              wr_en;
    khist_pkg::entry_t upd;
    logic [31:0]       tot_sum;

    assign accept     = req_valid && !req_stall;
    assign req_stall  = (state_reg != khist_pkg::ST_IDLE);
    assign hit        = pend_reg && (op_reg == khist_pkg::OP_RECORD)
                        && (rd_q_reg.key == key_reg);
    assign scan_end   = !pend_reg && (iss_idx_reg >= used_reg);
    assign table_full = (used_reg >= FULL_CNT);
    assign idx_ok     = (32'(req.entry_index) < 32'(used_reg))
                        && (32'(req.entry_index) < 32'(TABLE_ENTRIES));
    assign out_free   = !out_valid_reg || !rsp_stall;
    assign rsp_valid  = out_valid_reg;
    assign rsp        = rsp_reg;

    // Saturating count and total for the charged slot
    assign tot_sum   = {1'b0, cur_reg.total} + {1'b0, size_reg};
    assign upd.key   = cur_reg.key;
    assign upd.count = (cur_reg.count == khist_pkg::COUNT_MAX) ? cur_reg.count
                       : cur_reg.count + 32'd1;
    assign upd.total = (tot_sum > {1'b0, khist_pkg::TOTAL_MAX}) ? khist_pkg::TOTAL_MAX
                       : tot_sum[30:0];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tbl_mem[slot_reg] <= upd;
        end
        rd_q_reg <= tbl_mem[rd_addr];
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            khist_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    case (req.op)
                        khist_pkg::OP_CLEAR:   state_next = khist_pkg::ST_DONE;
                        khist_pkg::OP_READ:    state_next = idx_ok ? khist_pkg::ST_FETCH
                                                                   : khist_pkg::ST_DONE;
                        default:               state_next = khist_pkg::ST_SCAN;
                    endcase
                end
            end
            khist_pkg::ST_SCAN:
            begin
                if (hit)
                begin
                    state_next = khist_pkg::ST_UPDATE;
                end
                else if (scan_end)
                begin
                    if (op_reg == khist_pkg::OP_RECORD)
                    begin
                        state_next = table_full ? khist_pkg::ST_FETCH : khist_pkg::ST_UPDATE;
                    end
                    else
                    begin
                        state_next = khist_pkg::ST_DONE;
                    end
                end
            end
            khist_pkg::ST_FETCH:  state_next = khist_pkg::ST_LOAD;
            khist_pkg::ST_LOAD:   state_next = (op_reg == khist_pkg::OP_RECORD)
                                               ? khist_pkg::ST_UPDATE : khist_pkg::ST_DONE;
            khist_pkg::ST_UPDATE: state_next = khist_pkg::ST_DONE;
            khist_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    state_next = khist_pkg::ST_IDLE;
                end
            end
            default:              state_next = khist_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        op_next        = op_reg;
        key_next       = key_reg;
        size_next      = size_reg;
        limit_next     = limit_reg;
        used_next      = used_reg;
        iss_idx_next   = iss_idx_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        slot_next      = slot_reg;
        ovf_next       = ovf_reg;
        rd_ok_next     = rd_ok_reg;
        any_next       = any_reg;
        best_next      = best_reg;
        cur_next       = cur_reg;
        rsp_next       = rsp_reg;
        out_valid_next = out_valid_reg && rsp_stall;
        rd_addr        = slot_reg;
        wr_en          = 1'b0;
        case (state_reg)
            khist_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    op_next      = req.op;
                    key_next     = req.class_key;
                    size_next    = req.object_size;
                    limit_next   = req.limit_value;
                    iss_idx_next = '0;
                    pend_next    = 1'b0;
                    any_next     = 1'b0;
                    best_next    = '0;
                    ovf_next     = 1'b0;
                    rd_ok_next   = idx_ok;
                    slot_next    = IDX_W'(req.entry_index);
                    if (req.op == khist_pkg::OP_CLEAR)
                    begin
                        used_next = '0;
                    end
                end
            end
            khist_pkg::ST_SCAN:
            begin
                // issue the next used slot, compare the one read last cycle
                rd_addr = iss_idx_reg[IDX_W-1:0];
                if (iss_idx_reg < used_reg)
                begin
                    pend_next     = 1'b1;
                    pend_idx_next = iss_idx_reg[IDX_W-1:0];
                    iss_idx_next  = iss_idx_reg + CNT_W'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                end
                if (hit)
                begin
                    slot_next = pend_idx_reg;
                    cur_next  = rd_q_reg;
                    pend_next = 1'b0;
                end
                else if (pend_reg && (op_reg == khist_pkg::OP_LARGEST))
                begin
                    if ((rd_q_reg.total < limit_reg) && (!any_reg || (rd_q_reg.total > best_reg)))
                    begin
                        best_next = rd_q_reg.total;
                        any_next  = 1'b1;
                    end
                end
                if (scan_end && (op_reg == khist_pkg::OP_RECORD))
                begin
                    if (table_full)
                    begin
                        slot_next = LAST_SLOT;
                        ovf_next  = 1'b1;
                    end
                    else
                    begin
                        slot_next = used_reg[IDX_W-1:0];
                        cur_next  = '{key: key_reg, count: '0, total: '0};
                        used_next = used_reg + CNT_W'(1);
                    end
                end
            end
            khist_pkg::ST_FETCH:
            begin
                rd_addr = slot_reg;
            end
            khist_pkg::ST_LOAD:
            begin
                cur_next = rd_q_reg;
            end
            khist_pkg::ST_UPDATE:
            begin
                wr_en = 1'b1;
            end
            khist_pkg::ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next        = 1'b1;
                    rsp_next              = '0;
                    rsp_next.entries_used = 7'(used_reg);
                    case (op_reg)
                        khist_pkg::OP_RECORD:
                        begin
                            rsp_next.slot_used  = 6'(slot_reg);
                            rsp_next.overflowed = ovf_reg;
                        end
                        khist_pkg::OP_READ:
                        begin
                            if (rd_ok_reg)
                            begin
                                rsp_next.entry_valid = 1'b1;
                                rsp_next.entry_key   = cur_reg.key;
                                rsp_next.entry_count = cur_reg.count;
                                rsp_next.entry_total = cur_reg.total;
                            end
                        end
                        khist_pkg::OP_LARGEST:
                        begin
                            rsp_next.best_total = any_reg ? $signed({1'b0, best_reg})
                                                          : khist_pkg::LARGEST_NONE;
                        end
                        default:
                        begin
                            rsp_next.entries_used = 7'(used_reg);
                        end
                    endcase
                end
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= khist_pkg::ST_IDLE;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            used_reg      <= used_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        size_reg     <= size_next;
        limit_reg    <= limit_next;
        iss_idx_reg  <= iss_idx_next;
        pend_idx_reg <= pend_idx_next;
        slot_reg     <= slot_next;
        ovf_reg      <= ovf_next;
        rd_ok_reg    <= rd_ok_next;
        any_reg      <= any_next;
        best_reg     <= best_next;
        cur_reg      <= cur_next;
        rsp_reg      <= rsp_next;
    end

    `KHIST_ASSERT_IMPLIES(a_used_bound, clk, rst_n, 1'b1, used_reg <= FULL_CNT, "fill count past table depth")
    `KHIST_ASSERT_IMPLIES(a_update_slot, clk, rst_n, state_reg == khist_pkg::ST_UPDATE, 32'(slot_reg) < 32'(used_reg), "update outside used slots")
    `KHIST_ASSERT_IMPLIES(a_best_below, clk, rst_n, any_reg && state_reg == khist_pkg::ST_SCAN, best_reg < limit_reg, "search best not below limit")
    `KHIST_ASSERT_NEXT(a_clear_empty, clk, rst_n, accept && req.op == khist_pkg::OP_CLEAR, used_reg == '0, "clear left slots in use")

endmodule

### sim/tb_keyed_usage_histogram_table.sv
`timescale 1ns / 1ps
// Self-checking bench for keyed_usage_histogram_table: a directed stimulus table, then
// random clear/record/read/search traffic, each result beat checked against a typed
// row's want or the table model. Depends on khist_pkg and keyed_usage_histogram_table.
module tb_keyed_usage_histogram_table;
    import khist_pkg::*;

    localparam int SLOTS       = TABLE_ENTRIES_DEF;
    localparam int RAND_ITEMS  = 1700;
    localparam int CYCLE_LIMIT = 1000000;
    localparam int TAIL_CYCLES = 2 * SLOTS + 16;

    typedef enum {
        STALL_NONE,
        STALL_LIGHT,
        STALL_HEAVY,
        STALL_PERIODIC
    } stall_mode_t;

    typedef struct packed {
        req_t r;
        logic typed;
        rsp_t want;
    } stim_row_t;

    logic clk       = 1'b0;
    logic rst_n     = 1'b0;
    logic req_valid = 1'b0;
    logic req_stall;
    req_t req       = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_t rsp;

    logic [31:0] mdl_key   [SLOTS] = '{default: '0};
    logic [31:0] mdl_count [SLOTS] = '{default: '0};
    logic [30:0] mdl_total [SLOTS] = '{default: '0};
    int          mdl_used          = 0;

    rsp_t        due_rsp  [$];
    stim_row_t   dir_rows [$];
    logic [31:0] key_pool [$];
    int          mismatches = 0;
    int          burst_left = 0;
    int          cycles     = 0;
    stall_mode_t stall_mode = STALL_NONE;
    int          stall_run  = 0;
    int          stall_tick = 0;

    keyed_usage_histogram_table uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic rsp_t histogram_step(input req_t r);
        rsp_t        o;
        int          slot;
        logic        hit;
        logic        any;
        logic [30:0] best;
        logic [31:0] sum;
        o = '0;
        case (r.op)
            OP_CLEAR:
            begin
                for (int i = 0; i < SLOTS; i++)
                begin
                    mdl_key[i]   = '0;
                    mdl_count[i] = '0;
                    mdl_total[i] = '0;
                end
                mdl_used = 0;
            end
            OP_RECORD:
            begin
                hit  = 1'b0;
                slot = 0;
                for (int i = 0; i < mdl_used; i++)
                begin
                    if (!hit && mdl_key[i] == r.class_key)
                    begin
                        slot = i;
                        hit  = 1'b1;
                    end
                end
                if (!hit)
                begin
                    if (mdl_used < SLOTS)
                    begin
                        slot          = mdl_used;
                        mdl_key[slot] = r.class_key;
                        mdl_used++;
                    end
                    else
                    begin
                        slot         = SLOTS - 1;
                        o.overflowed = 1'b1;
                    end
                end
                if (mdl_count[slot] != COUNT_MAX)
                    mdl_count[slot] = mdl_count[slot] + 32'd1;
                sum             = {1'b0, mdl_total[slot]} + {1'b0, r.object_size};
                mdl_total[slot] = sum[31] ? TOTAL_MAX : sum[30:0];
                o.slot_used     = 6'(slot);
            end
            OP_READ:
            begin
                if (int'(r.entry_index) < mdl_used)
                begin
                    o.entry_valid = 1'b1;
                    o.entry_key   = mdl_key[r.entry_index];
                    o.entry_count = mdl_count[r.entry_index];
                    o.entry_total = mdl_total[r.entry_index];
                end
            end
            default:
            begin
                any  = 1'b0;
                best = '0;
                for (int i = 0; i < mdl_used; i++)
                begin
                    if (mdl_total[i] < r.limit_value && (!any || mdl_total[i] > best))
                    begin
                        best = mdl_total[i];
                        any  = 1'b1;
                    end
                end
                o.best_total = any ? {1'b0, best} : LARGEST_NONE;
            end
        endcase
        o.entries_used = 7'(mdl_used);
        return o;
    endfunction

    function automatic rsp_t rsp_lit(input logic [5:0] slot, input logic ovf, input logic vld,
                                     input logic [31:0] key, input logic [31:0] count,
                                     input logic [30:0] total, input logic [31:0] largest,
                                     input logic [6:0] used);
        rsp_t o;
        o.slot_used    = slot;
        o.overflowed   = ovf;
        o.entry_valid  = vld;
        o.entry_key    = key;
        o.entry_count  = count;
        o.entry_total  = total;
        o.best_total   = largest;
        o.entries_used = used;
        return o;
    endfunction

    function automatic void put_row(input op_t op, input logic [31:0] key,
                                    input logic [30:0] size, input logic [5:0] idx,
                                    input logic [30:0] lim, input logic typed, input rsp_t want);
        stim_row_t row;
        row.r.op          = op;
        row.r.class_key   = key;
        row.r.object_size = size;
        row.r.entry_index = idx;
        row.r.limit_value = lim;
        row.typed         = typed;
        row.want          = want;
        dir_rows.push_back(row);
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            mismatches++;
            $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
        end
    endtask

    // Drive one request beat; enter and leave at a falling edge.
    task automatic send_beat(input req_t r, input logic typed, input rsp_t want);
        rsp_t predicted;
        int   gap;
        int   roll;
        if (burst_left == 0)
        begin
            roll = $urandom_range(0, 9);
            if (roll < 4)
                gap = 0;
            else if (roll < 9)
                gap = $urandom_range(1, 8);
            else
                gap = $urandom_range(20, 90);
            if (gap > 0)
            begin
                req_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 16);
        end
        req       <= r;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
        predicted = histogram_step(r);
        due_rsp.push_back(typed ? want : predicted);
        burst_left--;
        @(negedge clk);
    endtask

    always @(negedge clk)
    begin
        if (stall_run == 0)
        begin
            stall_mode = stall_mode_t'($urandom_range(0, 3));
            stall_run  = $urandom_range(16, 300);
        end
        stall_run--;
        stall_tick++;
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            case (stall_mode)
                STALL_NONE:  rsp_stall <= 1'b0;
                STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
                STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
                default:     rsp_stall <= ((stall_tick % 7) < 3);
            endcase
    end

    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n && rsp_valid && !rsp_stall)
        begin
            if (due_rsp.size() == 0)
            begin
                mismatches++;
                $display("%0t: result beat with nothing expected, actual %h", $time, rsp);
            end
            else
            begin
                want = due_rsp.pop_front();
                check_field("slot_used", 32'(want.slot_used), 32'(rsp.slot_used));
                check_field("overflowed", 32'(want.overflowed), 32'(rsp.overflowed));
                check_field("entry_valid", 32'(want.entry_valid), 32'(rsp.entry_valid));
                check_field("entry_key", want.entry_key, rsp.entry_key);
                check_field("entry_count", want.entry_count, rsp.entry_count);
                check_field("entry_total", 32'(want.entry_total), 32'(rsp.entry_total));
                check_field("best_total", want.best_total, rsp.best_total);
                check_field("entries_used", 32'(want.entries_used), 32'(rsp.entries_used));
            end
        end
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("%0t: cycle limit hit, %0d results outstanding", $time, due_rsp.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        req_t        r;
        rsp_t        none;
        int          pool_n;
        int          n_ops;
        int          pick;
        int          sent;
        int          ep;
        logic [30:0] t;
        none = '0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        put_row(OP_READ, 32'h0, 31'h0, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd0));
        put_row(OP_READ, 32'hffffffff, 31'h7fffffff, 6'd63, 31'h7fffffff, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd0));
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h7fffffff, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, LARGEST_NONE, 7'd0));
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, LARGEST_NONE, 7'd0));
        put_row(OP_RECORD, 32'h0, 31'h7fffffff, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd1));
        put_row(OP_RECORD, 32'h0, 31'h7fffffff, 6'd63, 31'h7fffffff, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd1));
        put_row(OP_READ, 32'h0, 31'h0, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b1, 32'h0, 32'd2, 31'h7fffffff, 32'h0, 7'd1));
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h7fffffff, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, LARGEST_NONE, 7'd1));
        put_row(OP_RECORD, 32'hffffffff, 31'h0, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd1, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd2));
        put_row(OP_RECORD, 32'h12345678, 31'h1, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd2, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd3));
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h7fffffff, 1'b0, none);
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h1, 1'b0, none);
        put_row(OP_READ, 32'h0, 31'h0, 6'd1, 31'h0, 1'b0, none);
        put_row(OP_READ, 32'h0, 31'h0, 6'd3, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd3));
        put_row(OP_RECORD, 32'hffffffff, 31'h40000000, 6'd0, 31'h0, 1'b0, none);
        put_row(OP_RECORD, 32'hffffffff, 31'h40000000, 6'd0, 31'h0, 1'b0, none);
        put_row(OP_READ, 32'h0, 31'h0, 6'd1, 31'h0, 1'b0, none);
        put_row(OP_RECORD, 32'h0, 31'h0, 6'd0, 31'h0, 1'b0, none);
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h7ffffffe, 1'b0, none);
        put_row(OP_CLEAR, 32'hdeadbeef, 31'h7fffffff, 6'd63, 31'h7fffffff, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd0));
        put_row(OP_READ, 32'h0, 31'h0, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd0));
        put_row(OP_LARGEST, 32'h0, 31'h0, 6'd0, 31'h7fffffff, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, LARGEST_NONE, 7'd0));
        put_row(OP_RECORD, 32'ha5a5a5a5, 31'h5, 6'd0, 31'h0, 1'b1,
                rsp_lit(6'd0, 1'b0, 1'b0, 32'h0, 32'h0, 31'h0, 32'h0, 7'd1));

        foreach (dir_rows[k])
            send_beat(dir_rows[k].r, dir_rows[k].typed, dir_rows[k].want);

        sent = 0;
        ep   = 0;
        while (sent < RAND_ITEMS)
        begin
            ep++;
            // every third pass uses 60 to 90 keys, near or above the slot count, to fill the table
            pool_n = (ep % 3 == 1) ? $urandom_range(60, 90) : $urandom_range(1, 12);
            key_pool.delete();
            for (int k = 0; k < pool_n; k++)
            begin
                pick = $urandom_range(0, 19);
                key_pool.push_back(pick == 0 ? 32'h0 : (pick == 1 ? 32'hffffffff : $urandom));
            end
            n_ops = (pool_n > 12) ? $urandom_range(120, 220) : $urandom_range(15, 60);
            if ($urandom_range(0, 3) != 0)
            begin
                r.op          = OP_CLEAR;
                r.class_key   = $urandom;
                r.object_size = 31'($urandom);
                r.entry_index = 6'($urandom);
                r.limit_value = 31'($urandom);
                send_beat(r, 1'b0, none);
                sent++;
            end
            for (int k = 0; k < n_ops; k++)
            begin
                r.class_key   = $urandom;
                r.object_size = 31'($urandom);
                r.entry_index = 6'($urandom);
                r.limit_value = 31'($urandom);
                pick          = $urandom_range(0, 99);
                if (pick < 60)
                begin
                    r.op = OP_RECORD;
                    if ($urandom_range(0, 19) != 0)
                        r.class_key = key_pool[$urandom_range(0, pool_n - 1)];
                    case ($urandom_range(0, 9))
                        0:       r.object_size = '0;
                        1, 2, 3: r.object_size = 31'($urandom_range(0, 15));
                        4, 5, 6: r.object_size = 31'($urandom);
                        default: r.object_size = 31'($urandom_range(32'h40000000, 32'h7fffffff));
                    endcase
                end
                else if (pick < 80)
                begin
                    r.op = OP_READ;
                    if (mdl_used > 0 && $urandom_range(0, 1) == 1)
                        r.entry_index = 6'($urandom_range(0, mdl_used - 1));
                end
                else if (pick < 98)
                begin
                    r.op = OP_LARGEST;
                    pick = $urandom_range(0, 4);
                    if (mdl_used > 0 && pick < 2)
                    begin
                        t = mdl_total[$urandom_range(0, mdl_used - 1)];
                        r.limit_value = (pick == 0 || t == TOTAL_MAX) ? t : t + 31'd1;
                    end
                    else if (pick == 2)
                        r.limit_value = TOTAL_MAX;
                end
                else
                    r.op = OP_CLEAR;
                send_beat(r, 1'b0, none);
                sent++;
            end
        end

        req_valid <= 1'b0;
        while (due_rsp.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
